// ===== design/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assertion macros
// concurrent property checks that compile away in synthesis
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property that must hold at every clock edge outside reset
`define ASSERT_HOLDS(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// expression that must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`else

`define ASSERT_HOLDS(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg)

`endif

`endif

// ===== design/cfd_pkg.sv =====
// ---------------------------------------------------------------------------
// cfd_pkg
// shared types, constants and functions of the command frame deframer
// ---------------------------------------------------------------------------
package cfd_pkg;

  localparam logic [7:0] START_CODE_RST = 8'hAA;
  localparam logic [7:0] CRC_POLY       = 8'h07;
  localparam logic [5:0] FRAME_OVERHEAD = 6'd3;

  localparam logic [5:0] PLEN_NONE  = 6'd0;
  localparam logic [5:0] PLEN_SHORT = 6'd4;
  localparam logic [5:0] PLEN_MID   = 6'd20;
  localparam logic [5:0] PLEN_LONG  = 6'd32;

  typedef enum logic [2:0] {
    ST_HUNT,
    ST_TYPE,
    ST_BODY,
    ST_READ,
    ST_LOAD
  } cfd_state_t;

  // controller to datapath
  typedef struct packed {
    logic start_frame;
    logic take_type;
    logic take_body;
    logic emit_empty;
    logic emit_start;
    logic read_req;
    logic load_out;
  } cfd_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic start_hit;
    logic too_long;
    logic crc_byte;
    logic crc_ok;
    logic no_payload;
    logic last_idx;
    logic out_busy;
    logic out_free;
  } cfd_stat_t;

  // one byte through crc-8, msb first, no reflection
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

  function automatic logic [5:0] payload_len_of(input logic [7:0] t);
    logic [5:0] n;
    if (t < 8'd16) n = PLEN_NONE;
    else if (t < 8'd32) n = PLEN_SHORT;
    else if (t < 8'd48) n = PLEN_MID;
    else if (t < 8'd64) n = PLEN_LONG;
    else if (t < 8'd68) n = PLEN_NONE;
    else if (t < 8'd70) n = PLEN_SHORT;
    else if (t < 8'd71) n = PLEN_MID;
    else if (t < 8'd72) n = PLEN_LONG;
    else n = PLEN_NONE;
    return n;
  endfunction

endpackage

// ===== design/cfd_ram.sv =====
// ---------------------------------------------------------------------------
// cfd_ram
// generic simple dual-port ram, one write and one registered read port
// ---------------------------------------------------------------------------
module cfd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 40
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== design/cfd_dpath.sv =====
// ---------------------------------------------------------------------------
// cfd_dpath
// byte counters, running crc, payload store and result register
// ---------------------------------------------------------------------------
module cfd_dpath #(
  parameter int BUF_BYTES = 40
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_valid,
  input  logic [7:0]        cfg_data,
  input  logic [7:0]        rx_byte,
  input  cfd_pkg::cfd_cmd_t cmd,
  output cfd_pkg::cfd_stat_t stat,
  input  logic              out_ready,
  output logic              out_valid,
  output logic [7:0]        out_frame_type,
  output logic              out_is_query,
  output logic              out_has_payload,
  output logic [4:0]        out_payload_index,
  output logic [7:0]        out_payload_byte,
  output logic [5:0]        out_payload_len,
  output logic              out_last
);
  import cfd_pkg::*;

  localparam int         AW      = $clog2(BUF_BYTES);
  localparam logic [6:0] BUF_LEN = 7'(BUF_BYTES);

  logic [7:0] start_code_r, start_code_nxt;
  logic [5:0] byte_count_r, byte_count_nxt;
  logic [5:0] exp_len_r, exp_len_nxt;
  logic [7:0] crc_r, crc_nxt;
  logic [7:0] type_r, type_nxt;
  logic [5:0] plen_r, plen_nxt;
  logic [4:0] idx_r, idx_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_type_r;
  logic [4:0] out_idx_r;
  logic [7:0] out_byte_r;
  logic [5:0] out_len_r;
  logic       out_has_r;
  logic       out_last_r;

  logic [5:0] type_plen;
  logic [6:0] flen;
  logic [6:0] cnt_inc;
  logic [5:0] rd_pos;
  logic       ram_we;
  logic [7:0] ram_rdata;

  assign type_plen = payload_len_of(rx_byte);
  assign flen      = 7'(type_plen) + 7'(FRAME_OVERHEAD);
  assign cnt_inc   = {1'b0, byte_count_r} + 7'd1;
  assign rd_pos    = {1'b0, idx_r} + 6'd2;

  assign stat.start_hit  = (rx_byte == start_code_r);
  assign stat.too_long   = (flen > BUF_LEN);
  assign stat.crc_byte   = (cnt_inc >= {1'b0, exp_len_r});
  assign stat.crc_ok     = (crc_r == rx_byte);
  assign stat.no_payload = (plen_r == PLEN_NONE);
  assign stat.last_idx   = (({1'b0, idx_r} + 6'd1) == plen_r);
  assign stat.out_busy   = out_valid_r;
  assign stat.out_free   = !out_valid_r || out_ready;

  // payload bytes only; the start and type bytes are never read back
  assign ram_we = cmd.take_body && !stat.crc_byte && ({1'b0, byte_count_r} < BUF_LEN);

  cfd_ram #(
    .WIDTH(8),
    .DEPTH(BUF_BYTES)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(AW'(byte_count_r)),
    .wdata(rx_byte),
    .re   (cmd.read_req),
    .raddr(AW'(rd_pos)),
    .rdata(ram_rdata)
  );

  always_comb begin
    start_code_nxt = cfg_valid ? cfg_data : start_code_r;
    byte_count_nxt = byte_count_r;
    exp_len_nxt    = exp_len_r;
    crc_nxt        = crc_r;
    type_nxt       = type_r;
    plen_nxt       = plen_r;
    idx_nxt        = idx_r;
    if (cmd.start_frame) begin
      byte_count_nxt = 6'd1;
      crc_nxt        = crc8_byte(8'h00, rx_byte);
    end
    if (cmd.take_type) begin
      byte_count_nxt = 6'd2;
      exp_len_nxt    = flen[5:0];
      crc_nxt        = crc8_byte(crc_r, rx_byte);
      type_nxt       = rx_byte;
      plen_nxt       = type_plen;
    end
    if (cmd.take_body) begin
      byte_count_nxt = cnt_inc[5:0];
      if (!stat.crc_byte) begin
        crc_nxt = crc8_byte(crc_r, rx_byte);
      end
    end
    if (cmd.emit_start) begin
      idx_nxt = 5'd0;
    end
    if (cmd.load_out) begin
      idx_nxt = idx_r + 5'd1;
    end
    out_valid_nxt = (out_valid_r && !out_ready) || cmd.emit_empty || cmd.load_out;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_code_r <= START_CODE_RST;
      byte_count_r <= 6'd0;
      exp_len_r    <= 6'd0;
      crc_r        <= 8'h00;
      idx_r        <= 5'd0;
      out_valid_r  <= 1'b0;
    end else begin
      start_code_r <= start_code_nxt;
      byte_count_r <= byte_count_nxt;
      exp_len_r    <= exp_len_nxt;
      crc_r        <= crc_nxt;
      idx_r        <= idx_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    type_r <= type_nxt;
    plen_r <= plen_nxt;
    if (cmd.emit_empty) begin
      out_type_r <= type_r;
      out_has_r  <= 1'b0;
      out_idx_r  <= 5'd0;
      out_byte_r <= 8'h00;
      out_len_r  <= PLEN_NONE;
      out_last_r <= 1'b1;
    end else if (cmd.load_out) begin
      out_type_r <= type_r;
      out_has_r  <= 1'b1;
      out_idx_r  <= idx_r;
      out_byte_r <= ram_rdata;
      out_len_r  <= plen_r;
      out_last_r <= stat.last_idx;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_frame_type    = out_type_r;
  assign out_is_query      = out_type_r[7];
  assign out_has_payload   = out_has_r;
  assign out_payload_index = out_idx_r;
  assign out_payload_byte  = out_byte_r;
  assign out_payload_len   = out_len_r;
  assign out_last          = out_last_r;

endmodule

// ===== design/cfd_ctrl.sv =====
// ---------------------------------------------------------------------------
// cfd_ctrl
// frame parser state machine: hunt, type, body and payload read-out
// ---------------------------------------------------------------------------
module cfd_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  cfd_pkg::cfd_stat_t stat,
  output cfd_pkg::cfd_cmd_t  cmd
);
  import cfd_pkg::*;

  cfd_state_t state_r, state_nxt;
  logic       accept;
  logic       good_end;

  assign accept   = in_valid && in_ready;
  assign good_end = (state_r == ST_BODY) && accept && stat.crc_byte && stat.crc_ok;

  // the crc byte may produce a result, so it waits until the output register is empty
  always_comb begin
    unique case (state_r)
      ST_HUNT, ST_TYPE: in_ready = 1'b1;
      ST_BODY:          in_ready = !(stat.crc_byte && stat.out_busy);
      default:          in_ready = 1'b0;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_HUNT: begin
        if (accept && stat.start_hit) state_nxt = ST_TYPE;
      end
      ST_TYPE: begin
        if (accept) state_nxt = stat.too_long ? ST_HUNT : ST_BODY;
      end
      ST_BODY: begin
        if (accept && stat.crc_byte) begin
          state_nxt = (stat.crc_ok && !stat.no_payload) ? ST_READ : ST_HUNT;
        end
      end
      ST_READ: state_nxt = ST_LOAD;
      ST_LOAD: begin
        if (stat.out_free) state_nxt = stat.last_idx ? ST_HUNT : ST_READ;
      end
      default: state_nxt = ST_HUNT;
    endcase
  end

  always_comb begin
    cmd.start_frame = (state_r == ST_HUNT) && accept && stat.start_hit;
    cmd.take_type   = (state_r == ST_TYPE) && accept;
    cmd.take_body   = (state_r == ST_BODY) && accept;
    cmd.emit_empty  = good_end && stat.no_payload;
    cmd.emit_start  = good_end && !stat.no_payload;
    cmd.read_req    = (state_r == ST_READ);
    cmd.load_out    = (state_r == ST_LOAD) && stat.out_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_HUNT;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== design/crc8_command_frame_deframer.sv =====
// ---------------------------------------------------------------------------
// crc8_command_frame_deframer
// start-code framed command parser with crc-8 (poly 0x07) check
// ---------------------------------------------------------------------------
// results: a payload-free frame gives its result in the cycle after the crc byte;
//   a payload frame gives each result through a store read (ST_READ, registered
//   read) and an output load (ST_LOAD); input: 1 byte per cycle while parsing,
//   except that the crc byte waits for an empty output register; a good payload frame
//   emits one result per payload byte, with input held off until the last is loaded
// reset: synchronous active-low rst_n; hunting, start code 0xAA, no result
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module crc8_command_frame_deframer #(
  parameter int BUF_BYTES = 40
) (
  input  logic        clk,
  input  logic        rst_n,
  // config: start_code[7:0]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data,
  // rx_byte[7:0]
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,
  // frame_type[7:0], payload_index[12:8], payload_byte[20:13],
  // payload_len[26:21], zero[31:27]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,
  // is_query[0], has_payload[1]
  output logic [1:0]  out_tuser,
  output logic        out_tlast
);
  import cfd_pkg::*;

  cfd_cmd_t   cmd;
  cfd_stat_t  stat;
  logic [7:0] frame_type;
  logic       is_query;
  logic       has_payload;
  logic [4:0] payload_index;
  logic [7:0] payload_byte;
  logic [5:0] payload_len;

  assign cfg_ready = 1'b1;

  cfd_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_tvalid),
    .in_ready(in_tready),
    .stat    (stat),
    .cmd     (cmd)
  );

  cfd_dpath #(
    .BUF_BYTES(BUF_BYTES)
  ) u_dpath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_data         (cfg_data),
    .rx_byte          (in_tdata),
    .cmd              (cmd),
    .stat             (stat),
    .out_ready        (out_tready),
    .out_valid        (out_tvalid),
    .out_frame_type   (frame_type),
    .out_is_query     (is_query),
    .out_has_payload  (has_payload),
    .out_payload_index(payload_index),
    .out_payload_byte (payload_byte),
    .out_payload_len  (payload_len),
    .out_last         (out_tlast)
  );

  assign out_tdata = {5'd0, payload_len, payload_byte, payload_index, frame_type};
  assign out_tuser = {has_payload, is_query};

  `ASSERT_NEVER(a_empty_into_busy, clk, rst_n, cmd.emit_empty && out_tvalid, "result written over a waiting transaction")
  `ASSERT_HOLDS(a_load_needs_room, clk, rst_n, cmd.load_out |-> (!out_tvalid || out_tready), "payload result loaded while output stalled")
  `ASSERT_HOLDS(a_one_step, clk, rst_n, $onehot0({cmd.start_frame, cmd.take_type, cmd.take_body, cmd.read_req, cmd.load_out}), "more than one parser step in a cycle")
  `ASSERT_HOLDS(a_empty_is_last, clk, rst_n, (out_tvalid && !out_tuser[1]) |-> out_tlast, "payload-free result without last")

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// streams start-code command frames, good and corrupt, with noise between
// them, through the deframer and checks every emitted result transaction
// against a cycle-free model of the frame parser and its crc-8 check
// ---------------------------------------------------------------------------
module tb_top;

  localparam int CYCLE_LIMIT = 200000;
  localparam int STORE_BYTES = 40;
  localparam int LONG_HOLD   = 400;

  typedef enum logic [1:0] {
    PH_HUNT,
    PH_TYPE,
    PH_BODY
  } parse_phase_t;

  typedef struct {
    logic [7:0] frame_type;
    logic       is_query;
    logic       has_payload;
    logic [4:0] payload_index;
    logic [7:0] payload_byte;
    logic [5:0] payload_len;
    logic       last;
  } frame_beat_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_data = 8'h00;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        out_tlast;

  crc8_command_frame_deframer dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // stimulus and expectations
  logic [7:0]  rx_stream_q[$];
  logic [7:0]  body_q[$];
  frame_beat_t frame_beats_q[$];
  int          n_queued = 0;
  logic [7:0]  stim_start = 8'hAA;
  int          err_cnt = 0;
  int          cycle_cnt = 0;

  // handshake flags sampled at the rising edge, read at the falling edge
  bit in_took = 1'b0;
  bit cfg_took = 1'b0;

  // parser model state
  parse_phase_t fr_phase = PH_HUNT;
  logic [7:0]   fr_start = 8'hAA;
  logic [7:0]   fr_store [0:STORE_BYTES-1];
  logic [5:0]   fr_count = 6'd0;
  logic [5:0]   fr_len = 6'd0;
  logic [7:0]   fr_crc = 8'h00;

  // sender and receiver pacing
  int tx_burst = 0;
  int tx_gap = 0;
  int rdy_mode = 0;
  int rdy_span = 0;
  int hold_cnt = 0;
  bit want_long_hold = 1'b0;
  bit long_hold_done = 1'b0;

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic logic [7:0] crc8_step(input logic [7:0] c, input logic [7:0] b);
    logic [7:0] r;
    int         k;
    r = c ^ b;
    for (k = 0; k < 8; k++) begin
      r = {r[6:0], 1'b0} ^ (r[7] ? 8'h07 : 8'h00);
    end
    return r;
  endfunction

  function automatic int body_bytes(input logic [7:0] t);
    if ((t >= 8'd16 && t < 8'd32) || t == 8'd68 || t == 8'd69) return 4;
    if ((t >= 8'd32 && t < 8'd48) || t == 8'd70) return 20;
    if ((t >= 8'd48 && t < 8'd64) || t == 8'd71) return 32;
    return 0;
  endfunction

  function automatic void keep_byte(input logic [7:0] b);
    if (fr_count < STORE_BYTES) fr_store[fr_count] = b;
    fr_count = fr_count + 6'd1;
  endfunction

  // advance the parser by one accepted byte, queueing any frame it completes
  function automatic void parse_rx_byte(input logic [7:0] b);
    frame_beat_t bt;
    int          plen;
    int          i;
    case (fr_phase)
      PH_TYPE: begin
        keep_byte(b);
        if (3 + body_bytes(b) > STORE_BYTES) begin
          fr_phase = PH_HUNT;
        end else begin
          fr_len = 6'(3 + body_bytes(b));
          fr_crc = crc8_step(fr_crc, b);
          fr_phase = PH_BODY;
        end
      end
      PH_BODY: begin
        keep_byte(b);
        if (fr_count < fr_len) begin
          fr_crc = crc8_step(fr_crc, b);
        end else begin
          fr_phase = PH_HUNT;
          if (fr_crc == b) begin
            plen = int'(fr_len) - 3;
            bt.frame_type = fr_store[1];
            bt.is_query = fr_store[1][7];
            if (plen == 0) begin
              bt.has_payload = 1'b0;
              bt.payload_index = 5'd0;
              bt.payload_byte = 8'h00;
              bt.payload_len = 6'd0;
              bt.last = 1'b1;
              frame_beats_q.push_back(bt);
            end else begin
              for (i = 0; i < plen; i++) begin
                bt.has_payload = 1'b1;
                bt.payload_index = 5'(i);
                bt.payload_byte = (2 + i < STORE_BYTES) ? fr_store[2 + i] : 8'h00;
                bt.payload_len = 6'(plen);
                bt.last = (i == plen - 1);
                frame_beats_q.push_back(bt);
              end
            end
          end
        end
      end
      default: begin
        fr_phase = PH_HUNT;
        if (b == fr_start) begin
          fr_count = 6'd0;
          keep_byte(b);
          fr_crc = crc8_step(8'h00, b);
          fr_phase = PH_TYPE;
        end
      end
    endcase
  endfunction

  task automatic cmp_field(input string name, input logic [31:0] exp_v,
                           input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
      err_cnt++;
    end
  endtask

  task automatic check_beat();
    frame_beat_t w;
    if (frame_beats_q.size() == 0) begin
      $error("result with nothing expected: tdata 0x%0h tuser 0x%0h", out_tdata, out_tuser);
      err_cnt++;
    end else begin
      w = frame_beats_q.pop_front();
      cmp_field("frame_type", 32'(w.frame_type), 32'(out_tdata[7:0]));
      cmp_field("is_query", 32'(w.is_query), 32'(out_tuser[0]));
      cmp_field("has_payload", 32'(w.has_payload), 32'(out_tuser[1]));
      cmp_field("payload_index", 32'(w.payload_index), 32'(out_tdata[12:8]));
      cmp_field("payload_byte", 32'(w.payload_byte), 32'(out_tdata[20:13]));
      cmp_field("payload_len", 32'(w.payload_len), 32'(out_tdata[26:21]));
      cmp_field("tdata_pad", 32'd0, 32'(out_tdata[31:27]));
      cmp_field("last", 32'(w.last), 32'(out_tlast));
    end
  endtask

  // monitor
  always @(posedge clk) begin
    if (rst_n) begin
      in_took = in_tvalid && in_tready;
      cfg_took = cfg_valid && cfg_ready;
      if (cfg_took) fr_start = cfg_data;
      if (in_took) parse_rx_byte(in_tdata);
      if (out_tvalid && out_tready) check_beat();
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // sender: bursts of random length, random gaps between them
  always @(negedge clk) begin
    if (rst_n && (!in_tvalid || in_took)) begin
      if (tx_gap != 0) begin
        tx_gap--;
        in_tvalid <= 1'b0;
      end else if (rx_stream_q.size() != 0) begin
        in_tvalid <= 1'b1;
        in_tdata <= rx_stream_q.pop_front();
        if (tx_burst <= 1) begin
          tx_burst = $urandom_range(1, 40);
          tx_gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end else begin
          tx_burst--;
        end
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // receiver: stall pattern is redrawn when its random span runs out, one long hold-off
  always @(negedge clk) begin
    if (want_long_hold && !long_hold_done && out_tvalid) begin
      long_hold_done = 1'b1;
      hold_cnt = LONG_HOLD;
    end
    if (hold_cnt != 0) begin
      hold_cnt--;
      out_tready <= 1'b0;
    end else begin
      if (rdy_span == 0) begin
        rdy_mode = $urandom_range(0, 3);
        rdy_span = $urandom_range(8, 60);
      end
      rdy_span--;
      case (rdy_mode)
        0: out_tready <= 1'b1;
        1: out_tready <= 1'($urandom_range(0, 1));
        2: out_tready <= ($urandom_range(0, 3) == 0);
        default: out_tready <= ~out_tready;
      endcase
    end
  end

  function automatic void push_rx(input logic [7:0] b);
    rx_stream_q.push_back(b);
    n_queued++;
  endfunction

  // payload comes from body_q while it lasts, random after that
  function automatic void queue_frame(input logic [7:0] t, input bit corrupt);
    logic [7:0] c;
    logic [7:0] b;
    int         i;
    push_rx(stim_start);
    push_rx(t);
    c = crc8_step(crc8_step(8'h00, stim_start), t);
    for (i = 0; i < body_bytes(t); i++) begin
      b = (body_q.size() != 0) ? body_q.pop_front() : 8'($urandom_range(0, 255));
      push_rx(b);
      c = crc8_step(c, b);
    end
    if (corrupt) c = c ^ 8'($urandom_range(1, 255));
    push_rx(c);
  endfunction

  function automatic logic [7:0] pick_type();
    int k;
    k = $urandom_range(0, 99);
    if (k < 20) begin
      case ($urandom_range(0, 2))
        0: return 8'($urandom_range(0, 15));
        1: return 8'($urandom_range(64, 67));
        default: return 8'($urandom_range(72, 127));
      endcase
    end
    if (k < 35) return 8'($urandom_range(128, 255));
    if (k < 70) return ($urandom_range(0, 3) == 0) ? 8'($urandom_range(68, 69))
                                                   : 8'($urandom_range(16, 31));
    if (k < 85) return ($urandom_range(0, 3) == 0) ? 8'd70 : 8'($urandom_range(32, 47));
    return ($urandom_range(0, 3) == 0) ? 8'd71 : 8'($urandom_range(48, 63));
  endfunction

  // mostly well-formed frames, some corrupt, cut short or plain noise
  function automatic void queue_random_traffic(input int budget);
    int         stop_at;
    int         k;
    int         i;
    logic [7:0] t;
    stop_at = n_queued + budget;
    while (n_queued < stop_at) begin
      k = $urandom_range(0, 19);
      if (k < 15) begin
        queue_frame(pick_type(), 1'b0);
      end else if (k < 17) begin
        queue_frame(pick_type(), 1'b1);
      end else if (k < 19) begin
        for (i = $urandom_range(1, 3); i > 0; i--) push_rx(8'($urandom_range(0, 255)));
      end else begin
        // truncated frame: the bytes after it are taken as its remainder
        t = 8'($urandom_range(16, 63));
        push_rx(stim_start);
        push_rx(t);
        for (i = $urandom_range(0, body_bytes(t) - 1); i > 0; i--) begin
          push_rx(8'($urandom_range(0, 255)));
        end
      end
    end
  endfunction

  // wait until everything sent has been taken and answered, then let it settle
  task automatic wait_idle();
    while (rx_stream_q.size() != 0 || in_tvalid) @(posedge clk);
    while (frame_beats_q.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic write_start_code(input logic [7:0] v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(negedge clk);
    while (!cfg_took) @(negedge clk);
    cfg_valid <= 1'b0;
    stim_start = v;
  endtask

  initial begin
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: noise, type extremes, start code inside a frame, bad crc
    push_rx(8'hFF);
    queue_frame(8'h00, 1'b0);
    queue_frame(8'hFF, 1'b0);
    body_q.push_back(8'h00);
    body_q.push_back(8'hFF);
    body_q.push_back(8'hAA);
    body_q.push_back(8'h55);
    queue_frame(8'h10, 1'b0);
    queue_frame(8'hAA, 1'b0);
    queue_frame(8'h05, 1'b1);
    wait_idle();

    want_long_hold = 1'b1;
    queue_random_traffic(95);
    wait_idle();

    write_start_code(8'h00);
    queue_random_traffic(95);
    wait_idle();

    write_start_code(8'hFF);
    queue_random_traffic(95);
    wait_idle();

    write_start_code(8'($urandom_range(1, 254)));
    queue_random_traffic(95);
    wait_idle();

    if (err_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== crc8_command_frame_deframer.f =====
+incdir+design
design/cfd_pkg.sv
design/cfd_ram.sv
design/cfd_dpath.sv
design/cfd_ctrl.sv
design/crc8_command_frame_deframer.sv
verif/tb_top.sv
